@@ rtl/sha_pkg.sv @@
package sha_pkg;

  // one input word: up to eight message bytes, first byte in the top lane
  typedef struct packed {
    logic [63:0] message_chunk;
    logic [3:0]  valid_bytes;
    logic        last_chunk;
  } sha_in_t;

  // one output word of the digest
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } sha_out_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned ChunkBytes = 8;
  localparam int unsigned LenByte    = 56;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LastRound  = 6'd63;
  localparam logic [2:0]  LastWord   = 3'd7;

  localparam logic [31:0] IvHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_REM,
    ST_PAD,
    ST_OUT
  } top_state_e;

  // which block the running compression belongs to
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_LEN
  } phase_e;

  // compression unit
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FINAL
  } core_state_e;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/sha_if.sv @@
interface sha_in_if;
  import sha_pkg::*;
  logic    valid;
  logic    ready;
  sha_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
  import sha_pkg::*;
  logic     valid;
  logic     ready;
  sha_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sha_core.sv @@
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::core_ctl_t ctl_i,
  input  logic [511:0]       block_i,
  output sha_pkg::core_sts_t sts_o,
  output logic [255:0]       hash_o
);
  import sha_pkg::*;

  core_state_e cst_q, cst_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [31:0] hash_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] t1, t2, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one round of the shared unit
  always_comb begin
    t1 = v_q[7]
       + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + round_k(rnd_q) + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10))
          + w_q[9]
          + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
          + w_q[0];
  end

  always_comb begin
    cst_d = cst_q;
    rnd_d = rnd_q;
    sts_o.busy = (cst_q != CS_IDLE);
    sts_o.done = 1'b0;
    case (cst_q)
      CS_IDLE: begin
        if (ctl_i.start) begin
          cst_d = CS_ROUND;
          rnd_d = '0;
        end
      end
      CS_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          cst_d = CS_FINAL;
        end
      end
      CS_FINAL: begin
        sts_o.done = 1'b1;
        cst_d = CS_IDLE;
      end
      default: cst_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= CS_IDLE;
      rnd_q <= '0;
    end else begin
      cst_q <= cst_d;
      rnd_q <= rnd_d;
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= IvHash[i];
    end else if (cst_q == CS_FINAL) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= IvHash[i];
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (cst_q == CS_IDLE && ctl_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
    end else if (cst_q == CS_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255 - 32*i -: 32] = hash_q[i];
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> cst_q == CS_IDLE)
    else $error("start while compressing");

  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q == CS_ROUND && rnd_q == LastRound) |=> cst_q == CS_FINAL)
    else $error("round count overrun");

  a_stay_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q == CS_IDLE && !ctl_i.start) |=> cst_q == CS_IDLE)
    else $error("compression began without start");

  a_init_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.init |-> cst_q == CS_IDLE)
    else $error("reinit during compression");

endmodule

@@ rtl/sha256_hash_engine.sv @@
// sha-256 streaming hash engine
// input channel (chunk_i): one word carries up to eight message bytes, first
//   byte in bits 63..56, a count of valid leading bytes (values above eight
//   count as eight) and a last flag; short words may appear anywhere and
//   their bytes are packed on without gaps
// output channel (digest_o): after a last word, eight digest words, H0
//   first, with word_index 0..7 and digest_done on the eighth
// flow: a word that does not complete a 64-byte block is merged into the
//   buffer; a word that completes one holds the input off while the
//   shared round unit runs its 64 rounds, one per cycle, plus load,
//   feed-forward and remainder write; the round unit sets the sustained
//   rate on long messages
// a last word adds one padding compression, or two when more than 55
//   bytes are pending, then the digest words follow
// one item at a time: chunk_i.ready is high only while idle
// a stalled receiver simply holds the digest word steady; the hash state
//   returns to the initial values once the eighth word is taken
// reset clears length, fill count and state and loads the initial hash
module sha256_hash_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     chunk_i,
  sha_out_if.source  digest_o
);
  import sha_pkg::*;

  top_state_e   state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  total_q, total_d;
  logic [3:0]   rem_cnt_q, rem_cnt_d;
  logic [63:0]  rem_chunk_q, rem_chunk_d;
  logic [511:0] buf_q, buf_d;
  logic         last_q, last_d;
  logic         pad2_q, pad2_d;
  logic         start_q, start_d;
  logic [2:0]   idx_q, idx_d;
  logic         init;
  logic [3:0]   cnt;
  logic [6:0]   sum;
  logic [6:0]   skip;
  core_ctl_t    core_ctl;
  core_sts_t    core_sts;
  logic [255:0] hash;

  // write the first n bytes of data into the block from byte base on;
  // bytes that would land past the block end are left out
  function automatic logic [511:0] merge_bytes(input logic [511:0] blk,
                                               input logic [5:0] base,
                                               input logic [63:0] data,
                                               input logic [3:0] n);
    logic [511:0] res;
    logic [6:0]   d;
    res = blk;
    for (int p = 0; p < BlockBytes; p++) begin
      d = 7'(p) - {1'b0, base};
      if ((7'(p) >= {1'b0, base}) && (d < {3'b000, n})) begin
        res[511 - 8*p -: 8] = data[63 - 8*d[2:0] -: 8];
      end
    end
    return res;
  endfunction

  // pad byte at f, zeros after it, length in the last eight bytes if it fits
  function automatic logic [511:0] pad_block(input logic [511:0] blk,
                                             input logic [5:0] f,
                                             input logic [63:0] len);
    logic [511:0] res;
    res = blk;
    for (int p = 0; p < BlockBytes; p++) begin
      if (6'(p) == f) begin
        res[511 - 8*p -: 8] = PadByte;
      end else if (6'(p) > f) begin
        res[511 - 8*p -: 8] = 8'h00;
      end
    end
    if (f < 6'(LenByte)) begin
      res[63:0] = len;
    end
    return res;
  endfunction

  assign cnt  = (chunk_i.payload.valid_bytes > 4'(ChunkBytes)) ?
                4'(ChunkBytes) : chunk_i.payload.valid_bytes;
  assign sum  = {1'b0, fill_q} + {3'b000, cnt};
  // input bytes that still fit in the current block
  assign skip = 7'(BlockBytes) - {1'b0, fill_q};

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    total_d     = total_q;
    rem_cnt_d   = rem_cnt_q;
    rem_chunk_d = rem_chunk_q;
    buf_d       = buf_q;
    last_d      = last_q;
    pad2_d      = pad2_q;
    idx_d       = idx_q;
    start_d     = 1'b0;
    init        = 1'b0;
    chunk_i.ready  = 1'b0;
    digest_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        chunk_i.ready = 1'b1;
        if (chunk_i.valid) begin
          buf_d   = merge_bytes(buf_q, fill_q, chunk_i.payload.message_chunk, cnt);
          total_d = total_q + {57'd0, cnt, 3'b000};
          last_d  = chunk_i.payload.last_chunk;
          if (sum >= 7'(BlockBytes)) begin
            // block full: compress, keep the overflow bytes for afterwards
            rem_chunk_d = chunk_i.payload.message_chunk << {skip, 3'b000};
            rem_cnt_d   = sum[3:0];
            fill_d      = '0;
            phase_d     = PH_DATA;
            start_d     = 1'b1;
            state_d     = ST_WAIT;
          end else begin
            fill_d  = sum[5:0];
            state_d = chunk_i.payload.last_chunk ? ST_PAD : ST_IDLE;
          end
        end
      end
      ST_WAIT: begin
        if (core_sts.done) begin
          case (phase_q)
            PH_DATA: state_d = ST_REM;
            PH_PAD: begin
              if (pad2_q) begin
                // length did not fit: one more block of zeros and length
                buf_d   = {448'd0, total_q};
                phase_d = PH_LEN;
                start_d = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ST_OUT;
              end
            end
            PH_LEN: begin
              idx_d   = '0;
              state_d = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_REM: begin
        buf_d     = merge_bytes(buf_q, '0, rem_chunk_q, rem_cnt_q);
        fill_d    = {2'b00, rem_cnt_q};
        rem_cnt_d = '0;
        state_d   = last_q ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        buf_d   = pad_block(buf_q, fill_q, total_q);
        pad2_d  = (fill_q >= 6'(LenByte));
        phase_d = PH_PAD;
        start_d = 1'b1;
        state_d = ST_WAIT;
      end
      ST_OUT: begin
        digest_o.valid = 1'b1;
        if (digest_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastWord) begin
            init    = 1'b1;
            fill_d  = '0;
            total_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_DATA;
      fill_q    <= '0;
      total_q   <= '0;
      rem_cnt_q <= '0;
      last_q    <= 1'b0;
      pad2_q    <= 1'b0;
      start_q   <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      fill_q    <= fill_d;
      total_q   <= total_d;
      rem_cnt_q <= rem_cnt_d;
      last_q    <= last_d;
      pad2_q    <= pad2_d;
      start_q   <= start_d;
      idx_q     <= idx_d;
    end
  end

  // block buffer and overflow bytes
  always_ff @(posedge clk_i) begin
    buf_q       <= buf_d;
    rem_chunk_q <= rem_chunk_d;
  end

  assign core_ctl.start = start_q;
  assign core_ctl.init  = init;

  sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .block_i (buf_q),
    .sts_o   (core_sts),
    .hash_o  (hash)
  );

  assign digest_o.payload.digest_word = hash[255 - 32*idx_q -: 32];
  assign digest_o.payload.word_index  = idx_q;
  assign digest_o.payload.digest_done = (idx_q == LastWord);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chunk_i.ready && digest_o.valid))
    else $error("input taken while digest pending");

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && !start_q) |-> (core_sts.busy || core_sts.done))
    else $error("waiting on an idle compression unit");

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !core_sts.busy)
    else $error("digest shown before compression ended");

  a_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digest_o.valid && digest_o.ready && idx_q == LastWord) |=>
      (fill_q == '0 && total_q == '0))
    else $error("message state not cleared after digest");

endmodule
